### src/swmd_pkg.sv
`default_nettype none
package swmd_pkg;

  localparam int DELAY_W     = 32;
  localparam int RECV_TIME_W = 48;
  localparam int WINDOW_W    = 20;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(120000);

  // controller to datapath
  typedef struct packed {
    logic idle;            // ready for a new request
    logic exp_read;        // read time of oldest entry
    logic drop;            // release oldest entry
    logic mark_displaced;
    logic append;          // write new entry, start scan
    logic scan_issue;      // step the minimum scan
    logic publish;         // load output register
  } swmd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accepted;
    logic count_zero;
    logic expired;
    logic full;
    logic scan_done;
    logic out_free;
  } swmd_sts_t;

endpackage
`default_nettype wire

### src/swmd_if.sv
`default_nettype none
interface swmd_in_if;
  logic                             valid;
  logic                             ready;
  logic [swmd_pkg::DELAY_W-1:0]     delay_us;
  logic [swmd_pkg::RECV_TIME_W-1:0] arrival_ms;

  modport source (output valid, output delay_us, output arrival_ms, input ready);
  modport sink (input valid, input delay_us, input arrival_ms, output ready);
endinterface

interface swmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [swmd_pkg::DELAY_W-1:0] min_delay;
  logic                         displaced;

  modport source (output valid, output min_delay, output displaced, input ready);
  modport sink (input valid, input min_delay, input displaced, output ready);
endinterface
`default_nettype wire

### src/sliding_window_min_delay.sv
`default_nettype none
// Per request: expired entries are dropped from the oldest end (one time RAM
// read each), the oldest entry is dropped if the store is still full, the new
// entry is appended, the older entries kept are scanned (one delay RAM read a
// cycle), and the minimum is published once the output register is free.
// A new request is taken while the previous result waits.
// Reset (rst, synchronous): store empty, window length 120000 ms, no result.
module sliding_window_min_delay #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swmd_pkg::WINDOW_W-1:0] cfg_wdata,
  swmd_in_if.sink                            sample,
  swmd_out_if.source                         result
);
  import swmd_pkg::*;

  swmd_cmd_t cmd;
  swmd_sts_t sts;

  swmd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  swmd_dp #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

### src/swmd_ram.sv
`default_nettype none
module swmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/swmd_ctrl.sv
`default_nettype none
module swmd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swmd_pkg::swmd_sts_t sts,
  output swmd_pkg::swmd_cmd_t      cmd
);
  import swmd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXP_RD  = 7'b0000010,
    S_EXP_CHK = 7'b0000100,
    S_FULL    = 7'b0001000,
    S_APPEND  = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.accepted) begin
          state_next = S_EXP_RD;
        end
      end
      S_EXP_RD: begin
        if (sts.count_zero) begin
          state_next = S_FULL;
        end else begin
          cmd.exp_read = 1'b1;
          state_next   = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (sts.expired) begin
          cmd.drop   = 1'b1;
          state_next = S_EXP_RD;
        end else begin
          state_next = S_FULL;
        end
      end
      S_FULL: begin
        // drop the oldest live entry to make room
        if (sts.full) begin
          cmd.drop           = 1'b1;
          cmd.mark_displaced = 1'b1;
        end
        state_next = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/swmd_dp.sv
`default_nettype none
module swmd_dp #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swmd_pkg::WINDOW_W-1:0] cfg_wdata,
  swmd_in_if.sink                            sample,
  swmd_out_if.source                         result,
  input  wire swmd_pkg::swmd_cmd_t           cmd,
  output swmd_pkg::swmd_sts_t                sts
);
  import swmd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  logic [WINDOW_W-1:0]  window;
  logic [DELAY_W-1:0]   delay_in;
  logic [TIME_BITS-1:0] now;
  logic [IDX_W-1:0]     head;
  logic [CNT_W-1:0]     count;
  logic [DELAY_W-1:0]   best;
  logic [IDX_W-1:0]     scan_ptr;
  logic [CNT_W-1:0]     scan_left;
  logic                 rd_pend;
  logic                 displ;
  logic                 out_valid;
  logic [DELAY_W-1:0]   out_delay;
  logic                 out_displ;

  logic [TIME_BITS-1:0] time_rdata;
  logic [DELAY_W-1:0]   delay_rdata;
  logic [TIME_BITS-1:0] age;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     head_inc;
  logic [IDX_W-1:0]     scan_inc;
  logic                 scan_rd;
  logic                 accepted;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
    next_slot = (slot == LAST_IDX) ? '0 : slot + IDX_W'(1);
  endfunction

  assign accepted = sample.valid && cmd.idle;
  assign head_inc = next_slot(head);
  assign scan_inc = next_slot(scan_ptr);
  assign scan_rd  = cmd.scan_issue && (scan_left != '0);

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= DEPTH_SUM) begin
      tail_sum = tail_sum - DEPTH_SUM;
    end
    tail = tail_sum[IDX_W-1:0];
  end

  assign age = now - time_rdata;

  swmd_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail),
    .wdata (now),
    .re    (cmd.exp_read),
    .raddr (head),
    .rdata (time_rdata)
  );

  swmd_ram #(.WIDTH(DELAY_W), .DEPTH(DEPTH)) u_delay_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail),
    .wdata (delay_in),
    .re    (scan_rd),
    .raddr (scan_ptr),
    .rdata (delay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RESET;
      head      <= '0;
      count     <= '0;
      scan_left <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (cmd.drop) begin
        head  <= head_inc;
        count <= count - CNT_W'(1);
      end
      if (cmd.append) begin
        count     <= count + CNT_W'(1);
        scan_left <= count;
      end else if (scan_rd) begin
        scan_left <= scan_left - CNT_W'(1);
      end
      rd_pend <= scan_rd;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      delay_in <= sample.delay_us;
      now      <= TIME_BITS'(sample.arrival_ms);
      displ    <= 1'b0;
    end
    if (cmd.mark_displaced) begin
      displ <= 1'b1;
    end
    // new entry seeds the minimum; older entries follow one per cycle
    if (cmd.append) begin
      best     <= delay_in;
      scan_ptr <= head;
    end else if (scan_rd) begin
      scan_ptr <= scan_inc;
    end
    if (rd_pend && (delay_rdata < best)) begin
      best <= delay_rdata;
    end
    if (cmd.publish) begin
      out_delay <= best;
      out_displ <= displ;
    end
  end

  assign sts.accepted   = accepted;
  assign sts.count_zero = (count == '0);
  assign sts.expired    = CMP_W'(age) > CMP_W'(window);
  assign sts.full       = (count == FULL_CNT);
  assign sts.scan_done  = (scan_left == '0) && !rd_pend;
  assign sts.out_free   = !out_valid || result.ready;

  assign sample.ready      = cmd.idle;
  assign result.valid      = out_valid;
  assign result.min_delay  = out_delay;
  assign result.displaced  = out_displ;

endmodule
`default_nettype wire

### test/sliding_window_min_delay_checker.sv
`timescale 1ns / 100ps
module sliding_window_min_delay_checker #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swmd_pkg::WINDOW_W-1:0] cfg_wdata,
  swmd_in_if                                 sample,
  swmd_out_if                                result,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 requests_seen,
  output int                                 results_seen,
  output int                                 displaced_seen
);
  import swmd_pkg::*;

  typedef struct packed {
    logic [DELAY_W-1:0] min_delay;
    logic               displaced;
  } res_item_t;

  logic [DELAY_W-1:0]   held_delay [DEPTH];
  logic [TIME_BITS-1:0] held_time  [DEPTH];
  int unsigned          oldest;
  int unsigned          held;
  logic [WINDOW_W-1:0]  window_ms;

  res_item_t expected_base [$];
  res_item_t predicted;
  res_item_t oldest_expected;
  int        errors;
  int        n_req;
  int        n_res;
  int        n_disp;

  task automatic report(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    errors++;
  endtask

  task automatic predict_result(input logic [DELAY_W-1:0] delay,
                                input logic [TIME_BITS-1:0] now,
                                output res_item_t res);
    logic [TIME_BITS-1:0] age;
    logic [DELAY_W-1:0]   best;
    int unsigned          slot;
    int unsigned          k;
    bit                   expiring;
    res.displaced = 1'b0;
    expiring = 1'b1;
    // drop expired entries from the oldest end; ages wrap with the timestamp
    while (held > 0 && expiring) begin
      age = now - held_time[oldest];
      if (age > TIME_BITS'(window_ms)) begin
        oldest = (oldest + 1) % DEPTH;
        held--;
      end else begin
        expiring = 1'b0;
      end
    end
    if (held >= DEPTH) begin
      oldest = (oldest + 1) % DEPTH;
      held--;
      res.displaced = 1'b1;
    end
    slot = (oldest + held) % DEPTH;
    held_delay[slot] = delay;
    held_time[slot]  = now;
    held++;
    best = delay;
    slot = oldest;
    for (k = 0; k < held; k++) begin
      if (held_delay[slot] < best) best = held_delay[slot];
      slot = (slot + 1) % DEPTH;
    end
    res.min_delay = best;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      oldest    = 0;
      held      = 0;
      window_ms = WINDOW_RESET;
      expected_base.delete();
    end else begin
      if (cfg_we) window_ms = cfg_wdata;
      if (sample.valid && sample.ready) begin
        predict_result(sample.delay_us, sample.arrival_ms[TIME_BITS-1:0], predicted);
        expected_base.insert(expected_base.size(), predicted);
        n_req++;
        if (predicted.displaced) n_disp++;
      end
      if (result.valid && result.ready) begin
        n_res++;
        if (expected_base.size() == 0) begin
          report($sformatf("result min_delay %0h with no request outstanding",
                           result.min_delay));
        end else begin
          oldest_expected = expected_base.pop_front();
          if (result.min_delay !== oldest_expected.min_delay)
            report($sformatf("min_delay %0h, expected %0h (result %0d)",
                             result.min_delay, oldest_expected.min_delay, n_res));
          if (result.displaced !== oldest_expected.displaced)
            report($sformatf("displaced %b, expected %b (result %0d)",
                             result.displaced, oldest_expected.displaced, n_res));
        end
      end
    end
    fail_count     <= errors;
    outstanding    <= expected_base.size();
    requests_seen  <= n_req;
    results_seen   <= n_res;
    displaced_seen <= n_disp;
  end

endmodule

### test/sliding_window_min_delay_tb.sv
`timescale 1ns / 100ps
module sliding_window_min_delay_tb;
  import swmd_pkg::*;

  localparam int DEPTH           = 64;
  localparam int TIME_BITS       = 48;
  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int RANDOM_ITEMS    = 1530;
  localparam int PHASES          = 6;
  localparam int HOLD_OFF_CYCLES = 700;
  localparam int HOLD_OFF_AFTER  = 300;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [WINDOW_W-1:0]  cfg_wdata;

  swmd_in_if  sample_ch ();
  swmd_out_if result_ch ();

  int fail_count;
  int outstanding;
  int requests_seen;
  int results_seen;
  int displaced_seen;

  int                   cycles;
  int                   sent;
  int                   settings_used;
  bit                   steady;
  bit                   held_off;
  logic [TIME_BITS-1:0] last_time;
  logic [WINDOW_W-1:0]  window_now;

  sliding_window_min_delay #(
    .DEPTH(DEPTH),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .sample(sample_ch),
    .result(result_ch)
  );

  sliding_window_min_delay_checker #(
    .DEPTH(DEPTH),
    .TIME_BITS(TIME_BITS)
  ) window_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .sample(sample_ch),
    .result(result_ch),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .requests_seen(requests_seen),
    .results_seen(results_seen),
    .displaced_seen(displaced_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("sliding_window_min_delay_tb: done, errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    forever begin
      if (!held_off && requests_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (steady || $urandom_range(0, 2) != 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [DELAY_W-1:0] d, input logic [TIME_BITS-1:0] t);
    if (!steady && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.delay_us   <= d;
    sample_ch.arrival_ms <= t;
    do begin
      @(posedge clk);
    end while (!sample_ch.ready);
    last_time = t;
    sent++;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DELAY_W'($urandom_range(0, 4095));
      default: return DELAY_W'($urandom);
    endcase
  endfunction

  // one run of steadily advancing times, then one item that breaks the pattern
  task automatic send_sequence(input int phase_end);
    int                   run_len;
    int                   step_max;
    int                   step;
    logic [TIME_BITS-1:0] t;
    step_max = int'(window_now) / 40 + 1;
    run_len  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20))
                                           : int'($urandom_range(60, 150));
    for (int i = 0; i < run_len && sent < phase_end; i++) begin
      step = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, step_max));
      send_request(pick_delay(), last_time + TIME_BITS'(step));
    end
    case ($urandom_range(0, 4))
      0:       t = last_time + TIME_BITS'(window_now) + TIME_BITS'($urandom_range(1, 4));
      1:       t = last_time + TIME_BITS'(window_now);
      2:       t = {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(0, 40));
      3:       t = last_time - TIME_BITS'($urandom_range(1, 1000));
      default: t = TIME_BITS'({$urandom, $urandom});
    endcase
    send_request(pick_delay(), t);
  endtask

  initial begin
    int                  phase_end;
    logic [WINDOW_W-1:0] setting;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.delay_us   <= '0;
    sample_ch.arrival_ms <= '0;
    steady     = 1'b0;
    window_now = WINDOW_RESET;
    last_time  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window at its reset length
    send_request(DELAY_W'(1000), TIME_BITS'(0));
    send_request('1, TIME_BITS'(120000));          // age equal to the window: keep
    send_request(DELAY_W'(5), TIME_BITS'(120001)); // first entry one past the window
    send_request('0, '1);                          // far ahead: drop everything
    send_request('1, '0);                          // wrapped time, age one
    send_request(DELAY_W'(7), {TIME_BITS{1'b1}} - TIME_BITS'(4)); // earlier time: expire
    send_request(DELAY_W'(32'hAAAA_AAAA), TIME_BITS'(48'h5555_5555_5555));
    send_request(DELAY_W'(32'h5555_5555), TIME_BITS'(48'h5555_5555_5555));
    send_request(DELAY_W'(32'h8000_0000), TIME_BITS'(48'hAAAA_AAAA_AAAA));
    send_request(DELAY_W'(32'h7FFF_FFFF), TIME_BITS'(48'hAAAA_AAAA_AAAA));
    send_request(DELAY_W'(32'h7FFF_FFFE), TIME_BITS'(48'hAAAA_AAAA_AAAB));
    send_request('1, TIME_BITS'(48'h8000_0000_0000));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1:       setting = '0;
          2:       setting = '1;
          3:       setting = WINDOW_W'($urandom_range(1, 300));
          4:       setting = WINDOW_W'($urandom);
          default: setting = WINDOW_RESET;
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we     <= 1'b0;
        window_now  = setting;
        settings_used++;
      end
      // last phase runs flat out
      if (p == PHASES - 1) steady = 1'b1;
      phase_end = sent + RANDOM_ITEMS / PHASES;
      while (sent < phase_end) send_sequence(phase_end);
    end
    drain();

    $display("covered %0d requests and %0d results over %0d window settings, %0d displacing",
             requests_seen, results_seen, settings_used + 1, displaced_seen);
    $display("result side held off once for %0d cycles; final phase ran without idling",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sliding_window_min_delay_tb: done, clean");
    end else begin
      $display("sliding_window_min_delay_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/swmd_pkg.sv
src/swmd_if.sv
src/swmd_ram.sv
src/swmd_ctrl.sv
src/swmd_dp.sv
src/sliding_window_min_delay.sv
test/sliding_window_min_delay_checker.sv
test/sliding_window_min_delay_tb.sv
